>>> rtl/bfis_pkg.sv
// Package for the best-fit input selector: payload structs, result codes, widths.
// No dependencies.
package bfis_pkg;

    localparam int ValueW = 51;
    localparam int SumW   = 55;
    localparam int IdxW   = 8;

    typedef enum logic [2:0] {
        KIND_LOADED = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_CHOSEN = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_FAILED = 3'd4
    } kind_t;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SELECT = 1'b1
    } op_t;

    typedef struct packed {
        logic              operation;
        logic [ValueW-1:0] amount;
    } item_t;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [IdxW-1:0]   entry_index;
        logic [ValueW-1:0] entry_value;
        logic [SumW-1:0]   input_total;
        logic [SumW-1:0]   change_value;
        logic              last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_FAIL
    } state_t;

    // Best candidate that travels down the cell row.
    typedef struct packed {
        logic              exact;
        logic              over_ok;
        logic [SumW-1:0]   over_gap;
        logic [11:0]       over_slot;
        logic              under_ok;
        logic [SumW-1:0]   under_gap;
        logic [11:0]       under_slot;
    } cand_t;

endpackage

>>> rtl/bfis_cell.sv
// One table cell: holds a value and used mark, folds itself into the passing candidate
// and registers it for the next cell. Depends on bfis_pkg.
module bfis_cell
    import bfis_pkg::*;
#(
    parameter logic [11:0] SLOT = 12'd0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic [ValueW-1:0] load_value,
    input  logic              mark_en,
    input  logic              clear_mark,
    input  logic              live,
    input  logic [SumW-1:0]   target,
    input  cand_t             cand_in,
    output cand_t             cand_out,
    output logic [ValueW-1:0] value
);

    logic [ValueW-1:0] value_reg;
    logic              used_reg;
    logic [SumW-1:0]   v_ext;
    logic [SumW-1:0]   gap;
    logic              above;
    cand_t             cand_next;
    cand_t             cand_reg;

    // Hold the entry value; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            value_reg <= load_value;
        end
    end

    // Track the used mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else if (load_en || clear_mark)
        begin
            used_reg <= 1'b0;
        end
        else if (mark_en)
        begin
            used_reg <= 1'b1;
        end
    end

    assign value = value_reg;
    assign v_ext = {{(SumW-ValueW){1'b0}}, value_reg};
    assign above = v_ext > target;
    assign gap   = above ? (v_ext - target) : (target - v_ext);

    // Fold this entry into the candidate; earlier entries win ties
    always_comb
    begin
        cand_next = cand_in;
        if (live && !used_reg && !cand_in.exact)
        begin
            if (v_ext == target)
            begin
                cand_next.exact     = 1'b1;
                cand_next.over_ok   = 1'b1;
                cand_next.over_gap  = '0;
                cand_next.over_slot = SLOT;
            end
            else if (above)
            begin
                if (!cand_in.over_ok || gap < cand_in.over_gap)
                begin
                    cand_next.over_ok   = 1'b1;
                    cand_next.over_gap  = gap;
                    cand_next.over_slot = SLOT;
                end
            end
            else if (!cand_in.under_ok || gap < cand_in.under_gap)
            begin
                cand_next.under_ok   = 1'b1;
                cand_next.under_gap  = gap;
                cand_next.under_slot = SLOT;
            end
        end
    end

    // Hand the candidate to the next cell
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

>>> rtl/bfis_ctrl.sv
// Sequencer for loads and selection attempts over the cell row.
// Depends on bfis_pkg.
module bfis_ctrl
    import bfis_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_INPUTS  = 16,
    parameter int CNT_W       = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  item_t             item,
    input  logic [ValueW-1:0] fee,
    output logic              busy,
    output logic              done,
    output result_t           result,
    output logic [CNT_W-1:0]  entry_count,
    output logic              load_en,
    output logic              sel_en,
    output logic [11:0]       pick_slot,
    output logic [SumW-1:0]   target,
    input  cand_t             best,
    input  logic [ValueW-1:0] best_value
);

    localparam int ATT_W = $clog2(MAX_INPUTS) + 1;
    localparam logic [ATT_W-1:0] ATT_MAX = ATT_W'(MAX_INPUTS - 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SumW-1:0]     goal_reg, goal_next;
    logic [SumW-1:0]     rem_reg, rem_next;
    logic [SumW-1:0]     sum_reg, sum_next;
    logic [ATT_W-1:0]    att_reg, att_next;
    logic [ATT_W-1:0]    lim_reg, lim_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                hit_reg, hit_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;
    logic                have;
    logic [SumW-1:0]     new_sum;

    assign have    = best.over_ok || best.under_ok;
    assign pick_slot = best.over_ok ? best.over_slot : best.under_slot;
    assign new_sum = sum_reg + {{(SumW-ValueW){1'b0}}, best_value};

    // Update state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        goal_reg <= goal_next;
        rem_reg  <= rem_next;
        sum_reg  <= sum_next;
        att_reg  <= att_next;
        lim_reg  <= lim_next;
        scan_reg <= scan_next;
        hit_reg  <= hit_next;
        res_reg  <= res_next;
    end

    // Next state and results
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        goal_next  = goal_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        att_next   = att_reg;
        lim_next   = lim_reg;
        scan_next  = scan_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        res_next   = '0;
        load_en    = 1'b0;
        sel_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (item.operation == OP_LOAD)
                    begin
                        done_next     = 1'b1;
                        res_next.last = 1'b1;
                        if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            res_next.result_kind = KIND_FULL;
                        end
                        else
                        begin
                            load_en              = 1'b1;
                            res_next.result_kind = KIND_LOADED;
                            res_next.entry_index = count_reg[IdxW-1:0];
                            res_next.entry_value = item.amount;
                            count_next           = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        goal_next = {{(SumW-ValueW){1'b0}}, item.amount}
                                  + {{(SumW-ValueW){1'b0}}, fee};
                        rem_next  = goal_next;
                        sum_next  = '0;
                        att_next  = '0;
                        scan_next = '0;
                        hit_next  = 1'b0;
                        if (count_reg < CNT_W'(MAX_INPUTS - 1))
                            lim_next = ATT_W'(count_reg);
                        else
                            lim_next = ATT_MAX;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Wait until the candidate has passed every cell and reached the pick register
                if (att_reg >= lim_reg)
                    state_next = ST_FAIL;
                else if (scan_reg == CNT_W'(TABLE_DEPTH))
                    state_next = ST_PICK;
                else
                    scan_next = scan_reg + 1'b1;
            end
            ST_PICK:
            begin
                att_next   = att_reg + 1'b1;
                scan_next  = '0;
                state_next = ST_SCAN;
                if (have)
                begin
                    sel_en               = 1'b1;
                    done_next            = 1'b1;
                    res_next.result_kind = KIND_CHOSEN;
                    res_next.entry_index = pick_slot[IdxW-1:0];
                    res_next.entry_value = best_value;
                    sum_next             = new_sum;
                    rem_next             = rem_reg - {{(SumW-ValueW){1'b0}}, best_value};
                    if (new_sum >= goal_reg)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_FAIL;
                    end
                end
            end
            ST_FAIL:
            begin
                done_next     = 1'b1;
                res_next.last = 1'b1;
                state_next    = ST_IDLE;
                if (hit_reg)
                begin
                    res_next.result_kind  = KIND_DONE;
                    res_next.input_total  = sum_reg;
                    res_next.change_value = sum_reg - goal_reg;
                end
                else
                begin
                    res_next.result_kind = KIND_FAILED;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign result      = res_reg;
    assign entry_count = count_reg;
    assign target      = rem_reg;

endmodule

>>> rtl/best_fit_input_selector.sv
// Top level of the best-fit input selector: cell row plus sequencer.
// Depends on bfis_pkg, bfis_cell, bfis_ctrl.
//
// A load answers on done in the cycle after it is taken; loads can follow back to back. A
// select scans the cell row once per attempt: the candidate advances one cell per
// cycle, and each attempt runs the scan state and then the pick state. There are
// up to min(entry_count, MAX_INPUTS-1) attempts, then the final result comes from
// the ST_FAIL state. Results appear for one cycle on done and cannot be stalled. busy
// is high while a selection runs; the fee register is written through
// cfg_valid/cfg_ready, always ready.
module best_fit_input_selector
    import bfis_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int MAX_INPUTS  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ValueW-1:0] cfg_data
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W = $clog2(TABLE_DEPTH);

    logic [ValueW-1:0] fee_reg;
    logic [CNT_W-1:0]  entry_count;
    logic              load_en, sel_en;
    logic [11:0]       pick_slot;
    logic [SumW-1:0]   target;
    cand_t             chain [TABLE_DEPTH+1];
    logic [ValueW-1:0] values [TABLE_DEPTH];
    cand_t             best_reg;
    logic [ValueW-1:0] best_value_reg;
    logic [11:0]       best_slot;

    assign cfg_ready = 1'b1;

    // Hold the fee register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fee_reg <= '0;
        else if (cfg_valid && cfg_ready)
            fee_reg <= cfg_data;
    end

    assign chain[0] = '0;

    // Build the cell row
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        bfis_cell #(.SLOT(12'(i))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load_en   (load_en && entry_count == CNT_W'(i)),
            .load_value(item.amount),
            .mark_en   (sel_en && pick_slot == 12'(i)),
            .clear_mark(1'b0),
            .live      (CNT_W'(i) < entry_count),
            .target    (target),
            .cand_in   (chain[i]),
            .cand_out  (chain[i+1]),
            .value     (values[i])
        );
    end

    assign best_slot = chain[TABLE_DEPTH].over_ok ? chain[TABLE_DEPTH].over_slot
                                                  : chain[TABLE_DEPTH].under_slot;

    // Register the winner at the chain end
    always_ff @(posedge clk)
    begin
        best_reg       <= chain[TABLE_DEPTH];
        best_value_reg <= values[best_slot[SLOT_W-1:0]];
    end

    bfis_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_INPUTS (MAX_INPUTS),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .fee        (fee_reg),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .entry_count(entry_count),
        .load_en    (load_en),
        .sel_en     (sel_en),
        .pick_slot  (pick_slot),
        .target     (target),
        .best       (best_reg),
        .best_value (best_value_reg)
    );

endmodule

>>> tb/best_fit_input_selector_test.sv
// Self-checking bench for best_fit_input_selector: loads coin values, runs
// selections under several fee settings and checks every result. Depends on bfis_pkg, best_fit_input_selector.
module best_fit_input_selector_test;
    import bfis_pkg::*;

    localparam int Depth     = 256;
    localparam int MaxInputs = 16;
    localparam int CycleCap  = 3000000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              done;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ValueW-1:0] cfg_data;

    best_fit_input_selector #(.TABLE_DEPTH(Depth), .MAX_INPUTS(MaxInputs)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // Predictor state
    logic [ValueW-1:0] coin_value [Depth];
    logic              coin_spent [Depth];
    int                coin_count;
    logic [ValueW-1:0] fee_reg;

    item_t             pending_items [$];
    result_t           expected_results [$];
    int                fail_count;
    int                result_count;
    int                cycle_count;
    int                select_count;
    int                burst_left;
    int                gap_left;
    logic              taken;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t make_result(kind_t k, int slot, logic [ValueW-1:0] v,
                                            logic [SumW-1:0] tot, logic [SumW-1:0] chg,
                                            logic lst);
        result_t r;
        r.result_kind  = k;
        r.entry_index  = slot[IdxW-1:0];
        r.entry_value  = v;
        r.input_total  = tot;
        r.change_value = chg;
        r.last         = lst;
        return r;
    endfunction

    // Find the best-fitting unspent coin for the remaining target, -1 if none
    function automatic int best_coin(logic [SumW-1:0] want);
        int              over_slot;
        int              under_slot;
        logic [SumW-1:0] over_gap;
        logic [SumW-1:0] under_gap;
        logic [SumW-1:0] v;
        over_slot  = -1;
        under_slot = -1;
        over_gap   = '0;
        under_gap  = '0;
        for (int i = 0; i < coin_count; i++)
        begin
            if (!coin_spent[i])
            begin
                v = SumW'(coin_value[i]);
                if (v == want)
                    return i;
                if (v > want)
                begin
                    if (over_slot < 0 || v - want < over_gap)
                    begin
                        over_gap  = v - want;
                        over_slot = i;
                    end
                end
                else if (under_slot < 0 || want - v < under_gap)
                begin
                    under_gap  = want - v;
                    under_slot = i;
                end
            end
        end
        return (over_slot >= 0) ? over_slot : under_slot;
    endfunction

    // Work out the results of one accepted item and queue them
    task automatic predict_item(item_t it);
        logic [SumW-1:0] target;
        logic [SumW-1:0] remain;
        logic [SumW-1:0] total;
        int              slot;
        int              tries;
        target = '0;
        remain = '0;
        total  = '0;
        if (it.operation == OP_LOAD)
        begin
            if (coin_count >= Depth)
                expected_results.push_back(make_result(KIND_FULL, 0, '0, '0, '0, 1'b1));
            else
            begin
                coin_value[coin_count] = it.amount;
                coin_spent[coin_count] = 1'b0;
                expected_results.push_back(make_result(KIND_LOADED, coin_count,
                                                       it.amount, '0, '0, 1'b1));
                coin_count++;
            end
            return;
        end
        target = SumW'(it.amount) + SumW'(fee_reg);
        remain = target;
        tries  = (coin_count < MaxInputs - 1) ? coin_count : MaxInputs - 1;
        for (int a = 0; a < tries; a++)
        begin
            slot = best_coin(remain);
            if (slot >= 0)
            begin
                coin_spent[slot] = 1'b1;
                total += SumW'(coin_value[slot]);
                expected_results.push_back(make_result(KIND_CHOSEN, slot, coin_value[slot],
                                                       '0, '0, 1'b0));
                if (total >= target)
                begin
                    expected_results.push_back(make_result(KIND_DONE, 0, '0, total,
                                                           total - target, 1'b1));
                    return;
                end
                remain -= SumW'(coin_value[slot]);
            end
        end
        expected_results.push_back(make_result(KIND_FAILED, 0, '0, '0, '0, 1'b1));
    endtask

    // Driver: transfer queued items in bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && taken)
            begin
                if (gap_left == 0 && burst_left > 0 && pending_items.size() > 0)
                begin
                    item       <= pending_items.pop_front();
                    burst_left <= burst_left - 1;
                end
                else
                    start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() > 0)
                begin
                    if (burst_left == 0)
                        burst_left <= $urandom_range(1, 8) - 1;
                    else
                        burst_left <= burst_left - 1;
                    item  <= pending_items.pop_front();
                    start <= 1'b1;
                end
            end
            if (start && taken && (burst_left == 0 || pending_items.size() == 0))
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    // Monitor: note accepted items, predict, and check results
    always @(posedge clk)
    begin
        taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (start && !busy)
                predict_item(item);
            if (cfg_valid && cfg_ready)
                fee_reg <= cfg_data;
            if (done)
            begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result actual=%h", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                    check_result(expected_results.pop_front(), result);
            end
        end
    end

    task automatic check_result(result_t exp_r, result_t act_r);
        if (exp_r !== act_r)
        begin
            $display("%0t: mismatch kind exp=%0d act=%0d idx exp=%0d act=%0d", $time,
                     exp_r.result_kind, act_r.result_kind, exp_r.entry_index,
                     act_r.entry_index);
            $display("%0t:   value exp=%h act=%h total exp=%h act=%h", $time,
                     exp_r.entry_value, act_r.entry_value, exp_r.input_total,
                     act_r.input_total);
            $display("%0t:   change exp=%h act=%h last exp=%b act=%b", $time,
                     exp_r.change_value, act_r.change_value, exp_r.last, act_r.last);
            fail_count <= fail_count + 1;
        end
    endtask

    // Timeout guard
    always @(posedge clk)
    begin
        if (cycle_count > CycleCap)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [ValueW-1:0] rand_value();
        logic [ValueW-1:0] v;
        case ($urandom_range(0, 4))
            0: v = ValueW'($urandom_range(0, 40));
            1: v = ValueW'({$urandom, $urandom});
            2: v = {ValueW{1'b1}} - ValueW'($urandom_range(0, 3));
            default: v = ValueW'($urandom_range(0, 5000));
        endcase
        return v;
    endfunction

    function automatic item_t mk_item(op_t op, logic [ValueW-1:0] amt);
        item_t it;
        it.operation = op;
        it.amount    = amt;
        return it;
    endfunction

    // Wait until every queued item is taken and every result has come back
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (2 * MaxInputs + 8) @(posedge clk);
    endtask

    task automatic write_fee(logic [ValueW-1:0] fee);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= fee;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_phase(int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                pending_items.push_back(mk_item(OP_LOAD, rand_value()));
            else
            begin
                pending_items.push_back(mk_item(OP_SELECT, rand_value()));
                select_count++;
            end
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        fee_reg      = '0;
        coin_count   = 0;
        fail_count   = 0;
        result_count = 0;
        cycle_count  = 0;
        select_count = 0;
        burst_left   = 0;
        gap_left     = 0;
        taken        = 1'b0;
        for (int i = 0; i < Depth; i++)
        begin
            coin_value[i] = '0;
            coin_spent[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, zero target, exact, over, under, extremes
        pending_items.push_back(mk_item(OP_SELECT, '0));
        pending_items.push_back(mk_item(OP_LOAD, '0));
        pending_items.push_back(mk_item(OP_SELECT, '0));
        pending_items.push_back(mk_item(OP_LOAD, {ValueW{1'b1}}));
        pending_items.push_back(mk_item(OP_LOAD, 51'd10));
        pending_items.push_back(mk_item(OP_LOAD, 51'd25));
        pending_items.push_back(mk_item(OP_LOAD, 51'd25));
        pending_items.push_back(mk_item(OP_LOAD, 51'd7));
        pending_items.push_back(mk_item(OP_SELECT, 51'd25));
        pending_items.push_back(mk_item(OP_SELECT, 51'd20));
        pending_items.push_back(mk_item(OP_SELECT, 51'd100));
        pending_items.push_back(mk_item(OP_SELECT, {ValueW{1'b1}}));
        pending_items.push_back(mk_item(OP_SELECT, 51'd1));
        drain();

        write_fee({ValueW{1'b1}});
        pending_items.push_back(mk_item(OP_LOAD, 51'h2AAAA_AAAA_AAAA));
        pending_items.push_back(mk_item(OP_LOAD, 51'h5_5555_5555_5555));
        pending_items.push_back(mk_item(OP_SELECT, {ValueW{1'b1}}));
        pending_items.push_back(mk_item(OP_SELECT, '0));
        drain();

        // Random phases across fee settings
        write_fee(51'd3);
        queue_phase(45);
        drain();
        write_fee(ValueW'({$urandom, $urandom}));
        queue_phase(45);
        drain();
        write_fee('0);
        queue_phase(35);
        drain();

        $display("Ran %0d selections, %0d results, table holds %0d entries.",
                 select_count, result_count, coin_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
rtl/bfis_pkg.sv
rtl/bfis_cell.sv
rtl/bfis_ctrl.sv
rtl/best_fit_input_selector.sv
tb/best_fit_input_selector_test.sv
